>>> sv/grle_pkg.sv
// shared types and constants for the grid map run-length decoder
`default_nettype none

package grle_pkg;

   localparam int DIM_BITS_DEF = 32;
   localparam int FRAME_DIM_W  = 32;
   localparam int BYTE_W       = 8;
   localparam int COUNT_W      = 2;
   localparam int HDR_IDX_W    = 3;

   localparam logic [HDR_IDX_W-1:0] HDR_LAST = 3'd7;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_MUL,
      ST_CONTROL,
      ST_RUN,
      ST_EXPAND,
      ST_LITERAL
   } state_type;

   typedef struct packed {
      logic hdr_shift;
      logic mul_load;
      logic rc_load;
      logic val_load;
      logic lit_step;
      logic exp_step;
   } cmd_type;

   typedef struct packed {
      logic hdr_last;
      logic dim_zero;
      logic lit_ctl;
      logic rc_zero;
      logic rc_one;
      logic left_zero;
      logic left_le1;
      logic exp_run_end;
      logic exp_frame_end;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

>>> sv/grle_ctrl.sv
// controller state machine: sequences header, control, run and literal words
`default_nettype none

module grle_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  rsp_stall,
   input  grle_pkg::status_type sts,
   output grle_pkg::cmd_type    cmd
);

   grle_pkg::state_type state_ff, state_in;
   logic out_free;
   logic accept;

   assign out_free = !sts.out_busy || !rsp_stall;

   always_comb begin
      case (state_ff)
         grle_pkg::ST_HEADER,
         grle_pkg::ST_CONTROL,
         grle_pkg::ST_RUN:     req_stall = 1'b0;
         grle_pkg::ST_LITERAL: req_stall = !out_free;
         default:              req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grle_pkg::ST_HEADER: begin
            if (accept && sts.hdr_last) state_in = grle_pkg::ST_MUL;
         end
         grle_pkg::ST_MUL: begin
            state_in = sts.dim_zero ? grle_pkg::ST_HEADER : grle_pkg::ST_CONTROL;
         end
         grle_pkg::ST_CONTROL: begin
            if (accept) state_in = sts.lit_ctl ? grle_pkg::ST_LITERAL : grle_pkg::ST_RUN;
         end
         grle_pkg::ST_RUN: begin
            if (accept) begin
               if (sts.left_zero)    state_in = grle_pkg::ST_HEADER;
               else if (sts.rc_zero) state_in = grle_pkg::ST_CONTROL;
               else                  state_in = grle_pkg::ST_EXPAND;
            end
         end
         grle_pkg::ST_EXPAND: begin
            if (out_free && sts.exp_run_end) begin
               state_in = sts.exp_frame_end ? grle_pkg::ST_HEADER : grle_pkg::ST_CONTROL;
            end
         end
         grle_pkg::ST_LITERAL: begin
            if (accept && sts.rc_one) begin
               state_in = sts.left_le1 ? grle_pkg::ST_HEADER : grle_pkg::ST_CONTROL;
            end
         end
         default: state_in = grle_pkg::ST_HEADER;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd = '0;
      case (state_ff)
         grle_pkg::ST_HEADER:  cmd.hdr_shift = accept;
         grle_pkg::ST_MUL:     cmd.mul_load  = 1'b1;
         grle_pkg::ST_CONTROL: cmd.rc_load   = accept;
         grle_pkg::ST_RUN:     cmd.val_load  = accept;
         grle_pkg::ST_EXPAND:  cmd.exp_step  = out_free;
         grle_pkg::ST_LITERAL: cmd.lit_step  = accept;
         default:              cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grle_pkg::ST_HEADER;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/grle_dp.sv
// datapath: header words, cell counter, run counter and the result register
`default_nettype none

module grle_dp #(
   parameter int DIM_BITS = grle_pkg::DIM_BITS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire  [grle_pkg::BYTE_W-1:0]            req_stream_byte,
   input  wire                                    rsp_stall,
   input  grle_pkg::cmd_type                      cmd,
   output grle_pkg::status_type                   sts,
   output logic                                   rsp_valid,
   output logic [grle_pkg::BYTE_W-1:0]            rsp_cell_first,
   output logic [grle_pkg::BYTE_W-1:0]            rsp_cell_second,
   output logic [grle_pkg::COUNT_W-1:0]           rsp_byte_count,
   output logic                                   rsp_run_last,
   output logic                                   rsp_frame_last,
   output logic [grle_pkg::FRAME_DIM_W-1:0]       rsp_frame_width,
   output logic [grle_pkg::FRAME_DIM_W-1:0]       rsp_frame_height
);

   localparam int CELL_W = 2 * DIM_BITS;
   localparam int BW     = grle_pkg::BYTE_W;

   logic [grle_pkg::HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic [DIM_BITS-1:0]            width_ff, width_in;
   logic [DIM_BITS-1:0]            height_ff, height_in;
   logic [CELL_W-1:0]              left_ff, left_in;
   logic [BW-1:0]                  rc_ff, rc_in;
   logic [BW-1:0]                  value_ff, value_in;

   logic                           valid_ff, valid_in;
   logic [BW-1:0]                  first_ff, first_in;
   logic [BW-1:0]                  second_ff, second_in;
   logic [grle_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           rlast_ff, rlast_in;
   logic                           flast_ff, flast_in;
   logic [grle_pkg::FRAME_DIM_W-1:0] frame_w_ff, frame_w_in;
   logic [grle_pkg::FRAME_DIM_W-1:0] frame_h_ff, frame_h_in;

   logic                           take_two;
   logic [CELL_W-1:0]              take_cells;
   logic [BW-1:0]                  take_rc;
   logic                           left_nz;

   assign take_two   = (rc_ff >= BW'(2)) && (left_ff >= CELL_W'(2));
   assign take_cells = take_two ? CELL_W'(2) : CELL_W'(1);
   assign take_rc    = take_two ? BW'(2) : BW'(1);
   assign left_nz    = (left_ff != '0);

   always_comb begin
      sts.hdr_last      = (hdr_idx_ff == grle_pkg::HDR_LAST);
      sts.dim_zero      = (width_ff == '0) || (height_ff == '0);
      sts.lit_ctl       = (req_stream_byte != '0) && !req_stream_byte[BW-1];
      sts.rc_zero       = (rc_ff == '0);
      sts.rc_one        = (rc_ff == BW'(1));
      sts.left_zero     = !left_nz;
      sts.left_le1      = (left_ff <= CELL_W'(1));
      sts.exp_run_end   = (rc_ff == take_rc) || (left_ff == take_cells);
      sts.exp_frame_end = (left_ff == take_cells);
      sts.out_busy      = valid_ff;
   end

   always_comb begin
      hdr_idx_in = hdr_idx_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      left_in    = left_ff;
      rc_in      = rc_ff;
      value_in   = value_ff;
      valid_in   = valid_ff && rsp_stall;
      first_in   = first_ff;
      second_in  = second_ff;
      count_in   = count_ff;
      rlast_in   = rlast_ff;
      flast_in   = flast_ff;
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;

      if (cmd.hdr_shift) begin
         hdr_idx_in = hdr_idx_ff + grle_pkg::HDR_IDX_W'(1);
         // first four words build the width, the next four the height
         if (!hdr_idx_ff[grle_pkg::HDR_IDX_W-1]) begin
            width_in = DIM_BITS'({width_ff, req_stream_byte});
         end else begin
            height_in = DIM_BITS'({height_ff, req_stream_byte});
         end
      end

      if (cmd.mul_load) begin
         left_in = CELL_W'(width_ff) * CELL_W'(height_ff);
      end

      if (cmd.rc_load) begin
         // negative control word: repeat count is its magnitude
         rc_in = req_stream_byte[BW-1] ? (~req_stream_byte + BW'(1)) : req_stream_byte;
      end

      if (cmd.val_load) begin
         value_in = req_stream_byte;
      end

      if (cmd.lit_step) begin
         rc_in = rc_ff - BW'(1);
         if (left_nz) begin
            left_in    = left_ff - CELL_W'(1);
            valid_in   = 1'b1;
            first_in   = req_stream_byte;
            second_in  = '0;
            count_in   = grle_pkg::COUNT_W'(1);
            rlast_in   = 1'b1;
            flast_in   = (left_ff == CELL_W'(1));
            frame_w_in = grle_pkg::FRAME_DIM_W'(width_ff);
            frame_h_in = grle_pkg::FRAME_DIM_W'(height_ff);
         end
      end

      if (cmd.exp_step) begin
         rc_in      = rc_ff - take_rc;
         left_in    = left_ff - take_cells;
         valid_in   = 1'b1;
         first_in   = value_ff;
         second_in  = take_two ? value_ff : '0;
         count_in   = take_two ? grle_pkg::COUNT_W'(2) : grle_pkg::COUNT_W'(1);
         rlast_in   = sts.exp_run_end;
         flast_in   = sts.exp_frame_end;
         frame_w_in = grle_pkg::FRAME_DIM_W'(width_ff);
         frame_h_in = grle_pkg::FRAME_DIM_W'(height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         hdr_idx_ff <= hdr_idx_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff   <= width_in;
      height_ff  <= height_in;
      left_ff    <= left_in;
      rc_ff      <= rc_in;
      value_ff   <= value_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      count_ff   <= count_in;
      rlast_ff   <= rlast_in;
      flast_ff   <= flast_in;
      frame_w_ff <= frame_w_in;
      frame_h_ff <= frame_h_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_cell_first   = first_ff;
   assign rsp_cell_second  = second_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_run_last     = rlast_ff;
   assign rsp_frame_last   = flast_ff;
   assign rsp_frame_width  = frame_w_ff;
   assign rsp_frame_height = frame_h_ff;

endmodule

`default_nettype wire

>>> sv/grid_map_rle_decoder.sv
// Run-length decoder for grid map streams: one stream word in, up to two cells per result.
// Input channel req_: one byte per word. Each frame begins with eight header bytes,
// width then height, big-endian, of which the low DIM_BITS bits are kept.
// The body holds signed control bytes: negative repeats the next byte, positive
// copies that many literal bytes, zero skips one byte. Header and control bytes
// give no result; a frame of zero cells goes straight back to header parsing.
// Result channel rsp_: one or two cells per word plus run/frame end flags and the
// frame dimensions. A literal result shows in the cycle after its byte is taken; the first
// result of a run is formed in the expansion state after the run value byte, then registered.
// After the last header byte the controller passes through the cell-count multiplier
// state with req_stall high. A run value byte is followed by expansion, two cells per
// result word while two remain, over the run length clipped to the cells left, which
// waits while rsp_stall holds a word; req_stall is high meanwhile.
// Runs and literal groups are clipped at the frame's last cell.
// A single output register sits on the result side; while rsp_stall holds a word
// there, literal bytes and run expansion wait, header, control and run value
// bytes still flow.
// Synchronous reset returns to header parsing and empties the output register.
`default_nettype none

module grid_map_rle_decoder #(
   parameter int DIM_BITS = grle_pkg::DIM_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [grle_pkg::BYTE_W-1:0]        req_stream_byte,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [grle_pkg::BYTE_W-1:0]        rsp_cell_first,
   output logic [grle_pkg::BYTE_W-1:0]        rsp_cell_second,
   output logic [grle_pkg::COUNT_W-1:0]       rsp_byte_count,
   output logic                               rsp_run_last,
   output logic                               rsp_frame_last,
   output logic [grle_pkg::FRAME_DIM_W-1:0]   rsp_frame_width,
   output logic [grle_pkg::FRAME_DIM_W-1:0]   rsp_frame_height
);

   grle_pkg::cmd_type    cmd;
   grle_pkg::status_type sts;

   grle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   grle_dp #(
      .DIM_BITS (DIM_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_stream_byte  (req_stream_byte),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_cell_first   (rsp_cell_first),
      .rsp_cell_second  (rsp_cell_second),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_width  (rsp_frame_width),
      .rsp_frame_height (rsp_frame_height)
   );

endmodule

`default_nettype wire

>>> sv/grle_checker.sv
// port-level checks for the grid map run-length decoder, bound to the top level
`default_nettype none

module grle_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire [grle_pkg::BYTE_W-1:0]       rsp_cell_first,
   input wire [grle_pkg::BYTE_W-1:0]       rsp_cell_second,
   input wire [grle_pkg::COUNT_W-1:0]      rsp_byte_count,
   input wire                              rsp_run_last,
   input wire                              rsp_frame_last
);

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_first)
         && $stable(rsp_byte_count) && $stable(rsp_frame_last))
      else $error("stalled result word changed");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count == 2'd1) || (rsp_byte_count == 2'd2))
      else $error("cell count out of range");

   // frame end always closes the run that produced it
   a_frame_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_run_last)
      else $error("frame end without run end");

   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_count == 2'd1) |-> (rsp_cell_second == '0))
      else $error("unused second cell not cleared");

endmodule

bind grid_map_rle_decoder grle_checker u_grle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_cell_first  (rsp_cell_first),
   .rsp_cell_second (rsp_cell_second),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_run_last    (rsp_run_last),
   .rsp_frame_last  (rsp_frame_last)
);

`default_nettype wire

>>> test/grle_result_checker.sv
// checker for the grid map run-length decoder: predicts cell words and compares them
module grle_result_checker #(
   parameter int DIM_BITS = grle_pkg::DIM_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [grle_pkg::BYTE_W-1:0]         req_stream_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [grle_pkg::BYTE_W-1:0]         rsp_cell_first,
   input  logic [grle_pkg::BYTE_W-1:0]         rsp_cell_second,
   input  logic [grle_pkg::COUNT_W-1:0]        rsp_byte_count,
   input  logic                                rsp_run_last,
   input  logic                                rsp_frame_last,
   input  logic [grle_pkg::FRAME_DIM_W-1:0]    rsp_frame_width,
   input  logic [grle_pkg::FRAME_DIM_W-1:0]    rsp_frame_height,
   output int                                  mismatch_count,
   output int                                  words_due
);

   localparam logic [31:0] DIM_MASK = 32'((64'd1 << DIM_BITS) - 64'd1);
   localparam logic [7:0]  CTRL_SKIP = 8'h00;

   typedef enum logic [1:0] {
      AT_HEADER,
      AT_CONTROL,
      AT_RUN_VALUE,
      AT_LITERAL
   } parse_phase_type;

   typedef struct packed {
      logic [grle_pkg::BYTE_W-1:0]      cell_first;
      logic [grle_pkg::BYTE_W-1:0]      cell_second;
      logic [grle_pkg::COUNT_W-1:0]     byte_count;
      logic                             run_last;
      logic                             frame_last;
      logic [grle_pkg::FRAME_DIM_W-1:0] frame_width;
      logic [grle_pkg::FRAME_DIM_W-1:0] frame_height;
   } cell_word_type;

   cell_word_type   cell_words_due[$];
   parse_phase_type parse_phase;
   logic [grle_pkg::HDR_IDX_W-1:0] hdr_count;
   logic [31:0]  frame_w;
   logic [31:0]  frame_h;
   logic [63:0]  cells_total;
   logic [63:0]  cells_done;
   logic [7:0]   pending_count;
   int           mismatch_total = 0;

   initial begin
      mismatch_count = 0;
      words_due = 0;
   end

   function void clear_decoder();
      parse_phase   = AT_HEADER;
      hdr_count     = '0;
      frame_w       = '0;
      frame_h       = '0;
      cells_total   = '0;
      cells_done    = '0;
      pending_count = '0;
   endfunction

   function void emit_cells(input logic [7:0] a, input logic [7:0] b, input logic [1:0] take,
                            input logic rlast);
      cell_word_type w;
      w.cell_first   = a;
      w.cell_second  = (take == 2'd2) ? b : 8'h00;
      w.byte_count   = take;
      w.run_last     = rlast;
      w.frame_last   = (cells_done == cells_total);
      w.frame_width  = frame_w;
      w.frame_height = frame_h;
      cell_words_due = {cell_words_due, w};
   endfunction

   function void end_of_record();
      parse_phase = (cells_done >= cells_total) ? AT_HEADER : AT_CONTROL;
   endfunction

   function void decode_stream_byte(input logic [7:0] b);
      logic [63:0] run_cells;
      logic [1:0]  take;
      case (parse_phase)
         AT_HEADER: begin
            if (hdr_count < 3'd4) frame_w = {frame_w[23:0], b};
            else frame_h = {frame_h[23:0], b};
            if (hdr_count == grle_pkg::HDR_LAST) begin
               frame_w       = frame_w & DIM_MASK;
               frame_h       = frame_h & DIM_MASK;
               cells_total   = 64'(frame_w) * 64'(frame_h);
               cells_done    = '0;
               pending_count = '0;
               parse_phase   = (cells_total == 0) ? AT_HEADER : AT_CONTROL;
            end
            hdr_count = hdr_count + 3'd1;
         end
         AT_CONTROL: begin
            if (b[7]) begin
               pending_count = 8'(9'd256 - 9'(b));
               parse_phase   = AT_RUN_VALUE;
            end else if (b == CTRL_SKIP) begin
               pending_count = '0;
               parse_phase   = AT_RUN_VALUE;
            end else begin
               pending_count = b;
               parse_phase   = AT_LITERAL;
            end
         end
         AT_RUN_VALUE: begin
            run_cells = 64'(pending_count);
            if (run_cells > cells_total - cells_done) run_cells = cells_total - cells_done;
            while (run_cells != 0) begin
               take = (run_cells >= 2) ? 2'd2 : 2'd1;
               run_cells  = run_cells - 64'(take);
               cells_done = cells_done + 64'(take);
               emit_cells(b, b, take, run_cells == 0);
            end
            pending_count = '0;
            end_of_record();
         end
         default: begin
            // surplus literal bytes past the frame end are swallowed
            if (cells_done < cells_total) begin
               cells_done = cells_done + 64'd1;
               emit_cells(b, 8'h00, 2'd1, 1'b1);
            end
            if (pending_count != 0) pending_count = pending_count - 8'd1;
            if (pending_count == 0) end_of_record();
         end
      endcase
   endfunction

   function void check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_total++;
      end
   endfunction

   function void compare_cell_word();
      cell_word_type want;
      if (cell_words_due.size() == 0) begin
         $error("result word with nothing due: cell_first %0h byte_count %0d",
                rsp_cell_first, rsp_byte_count);
         mismatch_total++;
      end else begin
         want = cell_words_due.pop_front();
         check_field("cell_first", 32'(want.cell_first), 32'(rsp_cell_first));
         check_field("cell_second", 32'(want.cell_second), 32'(rsp_cell_second));
         check_field("byte_count", 32'(want.byte_count), 32'(rsp_byte_count));
         check_field("run_last", 32'(want.run_last), 32'(rsp_run_last));
         check_field("frame_last", 32'(want.frame_last), 32'(rsp_frame_last));
         check_field("frame_width", want.frame_width, rsp_frame_width);
         check_field("frame_height", want.frame_height, rsp_frame_height);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         cell_words_due.delete();
      end else begin
         // a result never belongs to a byte taken at the same edge
         if (rsp_valid && !rsp_stall) compare_cell_word();
         if (req_valid && !req_stall) decode_stream_byte(req_stream_byte);
      end
      mismatch_count <= mismatch_total;
      words_due      <= cell_words_due.size();
   end

endmodule

>>> test/tb_grid_map_rle_decoder.sv
// top of the grid map run-length decoder testbench: stimulus, receiver and verdict
module tb_grid_map_rle_decoder;

   localparam int         STREAM_BYTES = 270;
   localparam int         HOLD_CYCLES  = 300;
   localparam logic [7:0] CTRL_SKIP    = 8'h00;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [grle_pkg::BYTE_W-1:0] req_stream_byte = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [grle_pkg::BYTE_W-1:0]      rsp_cell_first;
   logic [grle_pkg::BYTE_W-1:0]      rsp_cell_second;
   logic [grle_pkg::COUNT_W-1:0]     rsp_byte_count;
   logic                             rsp_run_last;
   logic                             rsp_frame_last;
   logic [grle_pkg::FRAME_DIM_W-1:0] rsp_frame_width;
   logic [grle_pkg::FRAME_DIM_W-1:0] rsp_frame_height;

   int   mismatch_count;
   int   words_due;
   int   bytes_sent = 0;
   int   snd_idle_pct = 10;
   int   rcv_idle_pct = 51;
   logic hold_armed = 1'b0;
   logic hold_taken = 1'b0;

   grid_map_rle_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_first   (rsp_cell_first),
      .rsp_cell_second  (rsp_cell_second),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_width  (rsp_frame_width),
      .rsp_frame_height (rsp_frame_height)
   );

   grle_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_first   (rsp_cell_first),
      .rsp_cell_second  (rsp_cell_second),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_width  (rsp_frame_width),
      .rsp_frame_height (rsp_frame_height),
      .mismatch_count   (mismatch_count),
      .words_due        (words_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stall, plus one long hold-off to back up the block
   initial begin
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   // each cycle the sender idles with the current probability
   task automatic send_word(input logic [7:0] b);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [31:0] w, input logic [31:0] h);
      for (int i = 3; i >= 0; i--) send_word(w[8*i +: 8]);
      for (int i = 3; i >= 0; i--) send_word(h[8*i +: 8]);
   endtask

   task automatic send_random_frame();
      logic [31:0] w;
      logic [31:0] h;
      int left;
      int len;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         // empty frame with a full-range dimension on the other side
         w = $urandom;
         h = '0;
         if ($urandom_range(0, 1) == 1) begin
            h = w;
            w = '0;
         end
         send_header(w, h);
      end else begin
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 10);
         if (roll < 13) begin
            w = 32'd16;
            h = 32'd16;
         end
         send_header(w, h);
         left = int'(w * h);
         while (left > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               send_word(CTRL_SKIP);
               send_word(8'($urandom));
            end else if (roll < 55) begin
               len = $urandom_range(1, (left < 128) ? left : 128);
               if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 128);
               send_word(8'(256 - len));
               send_word(8'($urandom));
               left -= (len < left) ? len : left;
            end else begin
               len = $urandom_range(1, (left < 127) ? left : 127);
               // occasionally run a literal group past the frame end
               if ($urandom_range(0, 9) == 0) begin
                  len = left + $urandom_range(1, 8);
                  if (len > 127) len = 127;
               end
               send_word(8'(len));
               for (int i = 0; i < len; i++) send_word(8'($urandom));
               left -= (len < left) ? len : left;
            end
         end
      end
   endtask

   initial begin
      int guard;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // 3x1 frame: skip record, single run, literal group overrunning the end
      send_header(32'd3, 32'd1);
      send_word(CTRL_SKIP);
      send_word(8'h55);
      send_word(8'hFF);
      send_word(8'h00);
      send_word(8'h03);
      send_word(8'hFF);
      send_word(8'h80);
      send_word(8'h01);
      // 1x2 frame: longest run clipped at the frame end
      send_header(32'd1, 32'd2);
      send_word(8'h80);
      send_word(8'hAA);

      while (bytes_sent < STREAM_BYTES) begin
         if (bytes_sent < STREAM_BYTES / 3) begin
            snd_idle_pct = 10;
            rcv_idle_pct = 51;
         end else if (bytes_sent < 2 * STREAM_BYTES / 3) begin
            snd_idle_pct = 51;
            rcv_idle_pct = 10;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
            hold_armed <= 1'b1;
         end
         send_random_frame();
      end

      // widest frame: the cell count needs the full 64 bits and never ends here
      send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(8'h80);
      send_word(8'h5A);
      send_word(8'h02);
      send_word(8'h11);
      send_word(8'h22);
      req_valid <= 1'b0;

      guard = 0;
      while (words_due != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && words_due == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
